[rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// HTML syntax classifier package
// Shared types, character constants and opener tables of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

   // Scan phase of the front classifier.
   typedef enum logic [2:0] {
      PH_PLAIN      = 3'd0,
      PH_OPEN       = 3'd1,
      PH_TAG        = 3'd2,
      PH_TAG_EQ     = 3'd3,
      PH_QUOTE      = 3'd4,
      PH_COMMENT    = 3'd5,
      PH_NEST_START = 3'd6,
      PH_REST       = 3'd7
   } hsc_phase_type;

   // Class attached to every byte that leaves the block.
   typedef enum logic [2:0] {
      CLASS_PLAIN   = 3'd0,
      CLASS_TAG     = 3'd1,
      CLASS_ATTR    = 3'd2,
      CLASS_QUOTED  = 3'd3,
      CLASS_COMMENT = 3'd4,
      CLASS_SCRIPT  = 3'd5,
      CLASS_STYLE   = 3'd6
   } hsc_class_type;

   // Opener whose prefix sits in the hold buffer.
   typedef enum logic [1:0] {
      PAT_COMMENT    = 2'd0,
      PAT_END_SCRIPT = 2'd1,
      PAT_END_STYLE  = 2'd2
   } hsc_pat_type;

   // Nested block kind, also used as the candidate mask of the tag name match.
   localparam logic [1:0] NEST_NONE   = 2'd0;
   localparam logic [1:0] NEST_SCRIPT = 2'd1;
   localparam logic [1:0] NEST_STYLE  = 2'd2;
   localparam logic [1:0] NEST_BOTH   = 2'd3;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DASH   = 8'h2D;

   localparam logic [3:0] COMMENT_OPEN_LEN = 4'd4;
   localparam logic [3:0] END_SCRIPT_LEN   = 4'd9;
   localparam logic [3:0] END_STYLE_LEN    = 4'd8;
   localparam logic [2:0] WORD_SCRIPT_LEN  = 3'd6;
   localparam logic [2:0] WORD_STYLE_LEN   = 3'd5;

   // "<!--"
   localparam logic [7:0] COMMENT_OPEN [4] = '{8'h3C, 8'h21, 8'h2D, 8'h2D};
   // "</script>"
   localparam logic [7:0] END_SCRIPT [9] =
      '{8'h3C, 8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3E};
   // "</style>"
   localparam logic [7:0] END_STYLE [8] =
      '{8'h3C, 8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h3E};
   // "script" and "style"
   localparam logic [7:0] WORD_SCRIPT [6] = '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
   localparam logic [7:0] WORD_STYLE [5]  = '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65};

   // One classified character as handed from the front to the back: a run of
   // held opener bytes to release, then optionally the current character.
   typedef struct packed {
      logic [3:0]    flush_n;
      hsc_pat_type   flush_pat;
      hsc_class_type flush_cls;
      logic          has_char;
      logic [7:0]    ch;
      hsc_class_type ch_cls;
   } hsc_cmd_type;

   function automatic logic [7:0] hsc_pattern_byte(input hsc_pat_type pat,
                                                   input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (pat)
         PAT_COMMENT:    if (idx < COMMENT_OPEN_LEN) b = COMMENT_OPEN[idx[1:0]];
         PAT_END_SCRIPT: if (idx < END_SCRIPT_LEN) b = END_SCRIPT[idx];
         PAT_END_STYLE:  if (idx < END_STYLE_LEN) b = END_STYLE[idx[2:0]];
         default:        b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] hsc_word_byte(input logic pick_style,
                                                input logic [2:0] pos);
      logic [7:0] b;
      b = 8'h00;
      if (pick_style) begin
         if (pos < WORD_STYLE_LEN) b = WORD_STYLE[pos];
      end else begin
         if (pos < WORD_SCRIPT_LEN) b = WORD_SCRIPT[pos];
      end
      return b;
   endfunction

   function automatic logic hsc_name_done(input logic [1:0] kind, input logic [2:0] pos);
      return ((kind == NEST_SCRIPT) && (pos == WORD_SCRIPT_LEN)) ||
             ((kind == NEST_STYLE) && (pos == WORD_STYLE_LEN));
   endfunction

endpackage

`default_nettype wire

[rtl/hsc_front.sv]
// ----------------------------------------------------------------------------
// HTML syntax classifier front
// Accepts one transaction a cycle while q_full is low, tracks the scan state and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             req_mode,
   input  wire logic [7:0]       req_character,
   input  wire logic             q_full,
   output hsc_pkg::hsc_cmd_type  cmd,
   output logic                  cmd_push
);

   hsc_pkg::hsc_phase_type phase_ff, phase_in;
   logic [1:0]  nested_ff, nested_in;
   logic        quote_single_ff, quote_single_in;
   logic [1:0]  dash_run_ff, dash_run_in;
   logic [2:0]  match_pos_ff, match_pos_in;
   logic [1:0]  match_kind_ff, match_kind_in;
   logic [3:0]  hold_count_ff, hold_count_in;
   logic        in_attr_ff, in_attr_in;

   logic                   run_tag;
   logic                   quote_hit;
   logic [1:0]             new_kind;
   hsc_pkg::hsc_class_type deleg_cls;
   hsc_pkg::hsc_pat_type   end_pat;
   logic [3:0]             end_len;
   logic [7:0]             c;

   assign c = req_character;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hsc_pkg::PH_PLAIN;
         nested_ff       <= hsc_pkg::NEST_NONE;
         quote_single_ff <= 1'b0;
         dash_run_ff     <= 2'd0;
         match_pos_ff    <= 3'd0;
         match_kind_ff   <= hsc_pkg::NEST_NONE;
         hold_count_ff   <= 4'd0;
         in_attr_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         nested_ff       <= nested_in;
         quote_single_ff <= quote_single_in;
         dash_run_ff     <= dash_run_in;
         match_pos_ff    <= match_pos_in;
         match_kind_ff   <= match_kind_in;
         hold_count_ff   <= hold_count_in;
         in_attr_ff      <= in_attr_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      nested_in       = nested_ff;
      quote_single_in = quote_single_ff;
      dash_run_in     = dash_run_ff;
      match_pos_in    = match_pos_ff;
      match_kind_in   = match_kind_ff;
      hold_count_in   = hold_count_ff;
      in_attr_in      = in_attr_ff;

      cmd.flush_n   = 4'd0;
      cmd.flush_pat = hsc_pkg::PAT_COMMENT;
      cmd.flush_cls = hsc_pkg::CLASS_TAG;
      cmd.has_char  = 1'b0;
      cmd.ch        = c;
      cmd.ch_cls    = hsc_pkg::CLASS_PLAIN;

      run_tag   = 1'b0;
      quote_hit = 1'b0;
      new_kind  = hsc_pkg::NEST_NONE;
      deleg_cls = (nested_ff == hsc_pkg::NEST_SCRIPT) ? hsc_pkg::CLASS_SCRIPT
                                                      : hsc_pkg::CLASS_STYLE;
      end_pat   = (nested_ff == hsc_pkg::NEST_SCRIPT) ? hsc_pkg::PAT_END_SCRIPT
                                                      : hsc_pkg::PAT_END_STYLE;
      end_len   = (nested_ff == hsc_pkg::NEST_SCRIPT) ? hsc_pkg::END_SCRIPT_LEN
                                                      : hsc_pkg::END_STYLE_LEN;

      if (req_mode) begin
         // End of line: release what is held and close any open construct.
         case (phase_ff)
            hsc_pkg::PH_OPEN: begin
               cmd.flush_n   = hold_count_ff;
               cmd.flush_pat = hsc_pkg::PAT_COMMENT;
               cmd.flush_cls = hsc_pkg::CLASS_TAG;
            end
            hsc_pkg::PH_NEST_START: begin
               cmd.flush_n   = hold_count_ff;
               cmd.flush_pat = end_pat;
               cmd.flush_cls = deleg_cls;
            end
            default: begin
            end
         endcase
         if (phase_ff inside {hsc_pkg::PH_OPEN, hsc_pkg::PH_TAG, hsc_pkg::PH_TAG_EQ,
                              hsc_pkg::PH_QUOTE}) begin
            if (hsc_pkg::hsc_name_done(match_kind_ff, match_pos_ff)) begin
               nested_in = match_kind_ff;
            end
         end
         hold_count_in = 4'd0;
         dash_run_in   = 2'd0;
         in_attr_in    = 1'b0;
         match_kind_in = hsc_pkg::NEST_NONE;
         match_pos_in  = 3'd0;
         phase_in      = (nested_in != hsc_pkg::NEST_NONE) ? hsc_pkg::PH_NEST_START
                                                          : hsc_pkg::PH_PLAIN;
      end else begin
         case (phase_ff)
            hsc_pkg::PH_PLAIN: begin
               if (c == hsc_pkg::CH_LT) begin
                  hold_count_in = 4'd1;
                  phase_in      = hsc_pkg::PH_OPEN;
               end else begin
                  cmd.has_char = 1'b1;
                  cmd.ch_cls   = hsc_pkg::CLASS_PLAIN;
               end
            end
            hsc_pkg::PH_OPEN: begin
               if ((hold_count_ff < hsc_pkg::COMMENT_OPEN_LEN) &&
                   (c == hsc_pkg::hsc_pattern_byte(hsc_pkg::PAT_COMMENT, hold_count_ff))) begin
                  if (hold_count_ff == hsc_pkg::COMMENT_OPEN_LEN - 4'd1) begin
                     cmd.flush_n   = hold_count_ff;
                     cmd.flush_pat = hsc_pkg::PAT_COMMENT;
                     cmd.flush_cls = hsc_pkg::CLASS_COMMENT;
                     cmd.has_char  = 1'b1;
                     cmd.ch_cls    = hsc_pkg::CLASS_COMMENT;
                     hold_count_in = 4'd0;
                     dash_run_in   = 2'd2;
                     phase_in      = hsc_pkg::PH_COMMENT;
                  end else begin
                     hold_count_in = hold_count_ff + 4'd1;
                  end
               end else begin
                  // Not a comment: the held bytes open a tag, and a lone '<'
                  // leaves both nested openers as candidates.
                  match_kind_in = (hold_count_ff > 4'd1) ? hsc_pkg::NEST_NONE
                                                         : hsc_pkg::NEST_BOTH;
                  match_pos_in  = 3'd0;
                  cmd.flush_n   = hold_count_ff;
                  cmd.flush_pat = hsc_pkg::PAT_COMMENT;
                  cmd.flush_cls = hsc_pkg::CLASS_TAG;
                  hold_count_in = 4'd0;
                  in_attr_in    = 1'b0;
                  phase_in      = hsc_pkg::PH_TAG;
                  run_tag       = 1'b1;
               end
            end
            hsc_pkg::PH_TAG, hsc_pkg::PH_TAG_EQ: begin
               run_tag = 1'b1;
            end
            hsc_pkg::PH_QUOTE: begin
               cmd.has_char = 1'b1;
               cmd.ch_cls   = hsc_pkg::CLASS_QUOTED;
               if (c == (quote_single_ff ? hsc_pkg::CH_SQUOTE : hsc_pkg::CH_DQUOTE)) begin
                  phase_in = hsc_pkg::PH_TAG;
               end
            end
            hsc_pkg::PH_COMMENT: begin
               cmd.has_char = 1'b1;
               cmd.ch_cls   = hsc_pkg::CLASS_COMMENT;
               if (c == hsc_pkg::CH_DASH) begin
                  if (dash_run_ff < 2'd2) dash_run_in = dash_run_ff + 2'd1;
               end else if ((c == hsc_pkg::CH_GT) && (dash_run_ff == 2'd2)) begin
                  dash_run_in = 2'd0;
                  phase_in    = hsc_pkg::PH_PLAIN;
               end else begin
                  dash_run_in = 2'd0;
               end
            end
            hsc_pkg::PH_NEST_START: begin
               if ((hold_count_ff == 4'd0) &&
                   (c inside {hsc_pkg::CH_SPACE, [8'h09:8'h0D]})) begin
                  cmd.has_char = 1'b1;
                  cmd.ch_cls   = hsc_pkg::CLASS_PLAIN;
               end else if ((hold_count_ff < end_len) &&
                            (c == hsc_pkg::hsc_pattern_byte(end_pat, hold_count_ff))) begin
                  if (hold_count_ff + 4'd1 == end_len) begin
                     cmd.flush_n   = hold_count_ff;
                     cmd.flush_pat = end_pat;
                     cmd.flush_cls = hsc_pkg::CLASS_TAG;
                     cmd.has_char  = 1'b1;
                     cmd.ch_cls    = hsc_pkg::CLASS_TAG;
                     hold_count_in = 4'd0;
                     nested_in     = hsc_pkg::NEST_NONE;
                     phase_in      = hsc_pkg::PH_REST;
                  end else begin
                     hold_count_in = hold_count_ff + 4'd1;
                  end
               end else begin
                  cmd.flush_n   = hold_count_ff;
                  cmd.flush_pat = end_pat;
                  cmd.flush_cls = deleg_cls;
                  cmd.has_char  = 1'b1;
                  cmd.ch_cls    = deleg_cls;
                  hold_count_in = 4'd0;
                  phase_in      = hsc_pkg::PH_REST;
               end
            end
            hsc_pkg::PH_REST: begin
               cmd.has_char = 1'b1;
               cmd.ch_cls   = (nested_ff != hsc_pkg::NEST_NONE) ? deleg_cls
                                                                : hsc_pkg::CLASS_PLAIN;
            end
            default: begin
            end
         endcase

         if (run_tag) begin
            if (phase_in == hsc_pkg::PH_TAG_EQ) begin
               phase_in = hsc_pkg::PH_TAG;
               if ((c == hsc_pkg::CH_DQUOTE) || (c == hsc_pkg::CH_SQUOTE)) begin
                  quote_single_in = (c == hsc_pkg::CH_SQUOTE);
                  phase_in        = hsc_pkg::PH_QUOTE;
                  cmd.has_char    = 1'b1;
                  cmd.ch_cls      = hsc_pkg::CLASS_QUOTED;
                  quote_hit       = 1'b1;
               end
            end
            if (!quote_hit) begin
               // Narrow the nested opener candidates by one tag name byte.
               if ((match_kind_in != hsc_pkg::NEST_NONE) &&
                   !hsc_pkg::hsc_name_done(match_kind_in, match_pos_in)) begin
                  new_kind[0] = match_kind_in[0] && (match_pos_in < hsc_pkg::WORD_SCRIPT_LEN) &&
                                (c == hsc_pkg::hsc_word_byte(1'b0, match_pos_in));
                  new_kind[1] = match_kind_in[1] && (match_pos_in < hsc_pkg::WORD_STYLE_LEN) &&
                                (c == hsc_pkg::hsc_word_byte(1'b1, match_pos_in));
                  match_kind_in = new_kind;
                  if (new_kind != hsc_pkg::NEST_NONE) match_pos_in = match_pos_in + 3'd1;
               end
               cmd.has_char = 1'b1;
               if (c == hsc_pkg::CH_GT) begin
                  cmd.ch_cls = hsc_pkg::CLASS_TAG;
                  if (hsc_pkg::hsc_name_done(match_kind_in, match_pos_in)) begin
                     nested_in = match_kind_in;
                  end
                  match_kind_in = hsc_pkg::NEST_NONE;
                  match_pos_in  = 3'd0;
                  in_attr_in    = 1'b0;
                  phase_in      = hsc_pkg::PH_PLAIN;
               end else if ((c == hsc_pkg::CH_SPACE) && !in_attr_in) begin
                  in_attr_in = 1'b1;
                  cmd.ch_cls = hsc_pkg::CLASS_TAG;
               end else if (c == hsc_pkg::CH_EQUAL) begin
                  cmd.ch_cls = hsc_pkg::CLASS_ATTR;
                  phase_in   = hsc_pkg::PH_TAG_EQ;
               end else begin
                  cmd.ch_cls = in_attr_in ? hsc_pkg::CLASS_ATTR : hsc_pkg::CLASS_TAG;
               end
            end
         end
      end

      cmd_push = accept && ((cmd.flush_n != 4'd0) || cmd.has_char);
   end

   // Bytes are held back only while an opener is still undecided.
   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      (hold_count_ff != 4'd0) |->
         ((phase_ff == hsc_pkg::PH_OPEN) || (phase_ff == hsc_pkg::PH_NEST_START)))
      else $error("bytes held outside an opener phase");

   // The front never issues a command into a full queue.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command issued into a full queue");

endmodule

`default_nettype wire

[rtl/hsc_cmd_queue.sv]
// ----------------------------------------------------------------------------
// HTML syntax classifier command queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire hsc_pkg::hsc_cmd_type push_cmd,
   output logic                      full,
   input  wire logic                 pop,
   output hsc_pkg::hsc_cmd_type      head_cmd,
   output logic                      empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hsc_pkg::hsc_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   // The back only retires an entry that is present.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("command popped from an empty queue");

endmodule

`default_nettype wire

[rtl/hsc_back.sv]
// ----------------------------------------------------------------------------
// HTML syntax classifier back
// Expands each command into result bytes and holds them in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hsc_pkg::hsc_cmd_type head_cmd,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [7:0]                rsp_character_out,
   output logic [2:0]                rsp_text_class,
   output logic                      rsp_last
);

   logic [3:0]             idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             char_ff, char_in;
   hsc_pkg::hsc_class_type class_ff, class_in;
   logic                   last_ff, last_in;
   logic                   load;
   logic                   take;
   logic                   in_flush;

   assign empty             = !out_valid_ff;
   assign rsp_character_out = char_ff;
   assign rsp_text_class    = class_ff;
   assign rsp_last          = last_ff;

   always_comb begin
      take     = out_valid_ff && pop;
      load     = !q_empty && (!out_valid_ff || take);
      in_flush = (idx_ff < head_cmd.flush_n);

      if (in_flush) begin
         char_in  = hsc_pkg::hsc_pattern_byte(head_cmd.flush_pat, idx_ff);
         class_in = head_cmd.flush_cls;
         last_in  = (idx_ff == head_cmd.flush_n - 4'd1) && !head_cmd.has_char;
      end else begin
         char_in  = head_cmd.ch;
         class_in = head_cmd.ch_cls;
         last_in  = 1'b1;
      end

      q_pop        = load && last_in;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = last_in ? 4'd0 : idx_ff + 4'd1;
         out_valid_in = 1'b1;
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= char_in;
         class_ff <= class_in;
         last_ff  <= last_in;
      end
   end

   // A partly expanded command stays at the head of the queue.
   a_mid_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 4'd0) |-> !q_empty)
      else $error("expansion in progress without a queued command");

   // The next result after a last one starts a fresh command.
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (load && last_in) |=> (idx_ff == 4'd0))
      else $error("byte index not cleared after the final result");

endmodule

`default_nettype wire

[rtl/html_syntax_classifier.sv]
// ----------------------------------------------------------------------------
// HTML syntax classifier
// Classifies line text byte by byte into plain, tag, attribute, quoted value,
// comment, or script and style bytes that belong to a nested highlighter.
// ----------------------------------------------------------------------------
//
//   channel   ports                                      handshake
//   --------  -----------------------------------------  ---------------------
//   input     req_mode, req_character                    push high, full low
//   result    rsp_character_out, rsp_text_class, rsp_last empty low, pop high
//
// The front takes one transaction in every cycle while full is low and
// classifies it in that same cycle. A transaction causes up to nine results,
// because an undecided opener such as '</script' holds up to eight bytes that
// all leave together with the byte that decides it. The back drains results
// at one per cycle while pop is high; the held bytes came in with earlier
// transactions that caused none, so one transaction per cycle is sustained
// while pop is high. QUEUE_DEPTH commands plus the output register absorb the
// bursts, and full rises only while the queue holds QUEUE_DEPTH commands. With
// the back idle, the first result of a transaction passes through the queue
// and then the output register before it is shown. Reset is synchronous and
// clears the scan state, the queue and the output valid flag; a stalled
// result holds on the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module html_syntax_classifier #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_character,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_character_out,
   output logic [2:0]       rsp_text_class,
   output logic             rsp_last
);

   // Commands travel from the front into the queue and from its head into
   // the back. Each command names a run of held opener bytes and the current
   // byte, each with its class.
   hsc_pkg::hsc_cmd_type front_cmd;
   hsc_pkg::hsc_cmd_type head_cmd;
   logic                 front_push;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   logic                 accept;

   // An input transaction is taken whenever the queue has room. A transaction
   // that causes no result (an end of line with nothing held) just updates
   // the scan state.
   assign full   = q_full;
   assign accept = push && !q_full;

   // The front holds the whole scan state: phase, nested block kind, quote
   // style, the dash run of a comment, the tag name match, the attribute flag and
   // the count of held bytes. The held bytes are always a prefix of a known opener,
   // so the command carries which opener and how many, not the bytes themselves.
   hsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_mode      (req_mode),
      .req_character (req_character),
      .q_full        (q_full),
      .cmd           (front_cmd),
      .cmd_push      (front_push)
   );

   hsc_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   // The back walks the head command one result per cycle, regenerating the
   // held bytes from the opener tables, and retires the command with its
   // last result. The output register lets it keep going while pop is high.
   hsc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_character_out (rsp_character_out),
      .rsp_text_class    (rsp_text_class),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[dv/hsc_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTML syntax classifier checker package
// Holds a cycle-free model of the classifier and the in-order store of the
// classified characters that the block still owes.
// ----------------------------------------------------------------------------
package hsc_tb_pkg;

   localparam int MAX_PER_ITEM = 9;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] NESTED_SCRIPT = 2'd1;
   localparam logic [1:0] NESTED_STYLE  = 2'd2;
   localparam logic [1:0] NAME_BOTH     = 2'd3;

   localparam logic [7:0] ASCII_LT     = 8'h3C;
   localparam logic [7:0] ASCII_GT     = 8'h3E;
   localparam logic [7:0] ASCII_SPACE  = 8'h20;
   localparam logic [7:0] ASCII_EQUAL  = 8'h3D;
   localparam logic [7:0] ASCII_DQUOTE = 8'h22;
   localparam logic [7:0] ASCII_SQUOTE = 8'h27;
   localparam logic [7:0] ASCII_DASH   = 8'h2D;

   typedef struct {
      logic [7:0]             ch;
      hsc_pkg::hsc_class_type cls;
      logic                   is_last;
   } classified_char_type;

   class char_class_tracker_type;
      string comment_open = "<!--";
      string close_script = "</script>";
      string close_style  = "</style>";
      string script_word  = "script";
      string style_word   = "style";

      logic [1:0]             nest_kind;
      hsc_pkg::hsc_phase_type phase;
      logic                   quote_single;
      logic [1:0]             dash_cnt;
      logic [2:0]             match_pos;
      logic [1:0]             match_kind;
      logic [7:0]             held [8];
      logic [3:0]             held_n;
      logic                   in_attr;

      classified_char_type step_q[$];
      classified_char_type pending_classified[$];
      int errors;
      int items_seen;
      int results_checked;
      int nest_entries;

      function new();
         nest_kind    = KIND_NONE;
         phase        = hsc_pkg::PH_PLAIN;
         quote_single = 1'b0;
         dash_cnt     = '0;
         match_pos    = '0;
         match_kind   = KIND_NONE;
         held_n       = '0;
         in_attr      = 1'b0;
         foreach (held[i]) held[i] = '0;
         errors = 0;
         items_seen = 0;
         results_checked = 0;
         nest_entries = 0;
      endfunction

      function logic [7:0] pat_byte(string s, int idx);
         return s[idx];
      endfunction

      function bit is_nested();
         return nest_kind != KIND_NONE;
      endfunction

      function int pending();
         return pending_classified.size();
      endfunction

      function void emit(logic [7:0] c, hsc_pkg::hsc_class_type cls);
         if (step_q.size() < MAX_PER_ITEM)
            step_q.push_back('{ch: c, cls: cls, is_last: 1'b0});
      endfunction

      function void flush_held(hsc_pkg::hsc_class_type cls);
         for (int k = 0; k < held_n && k < 8; k++) emit(held[k], cls);
         held_n = '0;
      endfunction

      function hsc_pkg::hsc_class_type nested_class();
         return (nest_kind == NESTED_SCRIPT) ? hsc_pkg::CLASS_SCRIPT : hsc_pkg::CLASS_STYLE;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == ASCII_SPACE || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit name_done();
         return (match_kind == NESTED_SCRIPT && match_pos == 3'd6) ||
                (match_kind == NESTED_STYLE && match_pos == 3'd5);
      endfunction

      function void name_step(logic [7:0] c);
         logic [2:0] p;
         logic [1:0] nk;
         p = match_pos;
         nk = KIND_NONE;
         if (match_kind == KIND_NONE || name_done()) return;
         if (match_kind[0] && p < 3'd6 && c == pat_byte(script_word, p)) nk[0] = 1'b1;
         if (match_kind[1] && p < 3'd5 && c == pat_byte(style_word, p)) nk[1] = 1'b1;
         match_kind = nk;
         if (nk != KIND_NONE) match_pos = p + 3'd1;
      endfunction

      function void close_tag();
         if (name_done()) begin
            nest_kind = match_kind;
            nest_entries++;
         end
         match_kind = KIND_NONE;
         match_pos  = '0;
         in_attr    = 1'b0;
         phase      = hsc_pkg::PH_PLAIN;
      endfunction

      function void tag_byte(logic [7:0] c);
         if (phase == hsc_pkg::PH_TAG_EQ) begin
            phase = hsc_pkg::PH_TAG;
            if (c == ASCII_DQUOTE || c == ASCII_SQUOTE) begin
               quote_single = (c == ASCII_SQUOTE);
               phase = hsc_pkg::PH_QUOTE;
               emit(c, hsc_pkg::CLASS_QUOTED);
               return;
            end
         end
         name_step(c);
         if (c == ASCII_GT) begin
            emit(c, hsc_pkg::CLASS_TAG);
            close_tag();
            return;
         end
         if (c == ASCII_SPACE && !in_attr) begin
            in_attr = 1'b1;
            emit(c, hsc_pkg::CLASS_TAG);
            return;
         end
         if (c == ASCII_EQUAL) begin
            emit(c, hsc_pkg::CLASS_ATTR);
            phase = hsc_pkg::PH_TAG_EQ;
            return;
         end
         emit(c, in_attr ? hsc_pkg::CLASS_ATTR : hsc_pkg::CLASS_TAG);
      endfunction

      function void opener_failed(logic [7:0] c);
         // Only a bare '<' still allows the tag name to become script or style.
         match_kind = (held_n > 4'd1) ? KIND_NONE : NAME_BOTH;
         match_pos  = '0;
         flush_held(hsc_pkg::CLASS_TAG);
         in_attr = 1'b0;
         phase   = hsc_pkg::PH_TAG;
         tag_byte(c);
      endfunction

      function void nested_byte(logic [7:0] c);
         string pat;
         int    len;
         pat = (nest_kind == NESTED_SCRIPT) ? close_script : close_style;
         len = pat.len();
         if (held_n == 0 && is_blank(c)) begin
            emit(c, hsc_pkg::CLASS_PLAIN);
            return;
         end
         if (held_n < len && c == pat_byte(pat, held_n)) begin
            if (held_n + 1 == len) begin
               flush_held(hsc_pkg::CLASS_TAG);
               emit(c, hsc_pkg::CLASS_TAG);
               nest_kind = KIND_NONE;
               phase = hsc_pkg::PH_REST;
            end else if (held_n < 8) begin
               held[held_n[2:0]] = c;
               held_n++;
            end
            return;
         end
         flush_held(nested_class());
         emit(c, nested_class());
         phase = hsc_pkg::PH_REST;
      endfunction

      function void text_byte(logic [7:0] c);
         case (phase)
            hsc_pkg::PH_PLAIN: begin
               if (c == ASCII_LT) begin
                  held[0] = c;
                  held_n  = 4'd1;
                  phase   = hsc_pkg::PH_OPEN;
               end else begin
                  emit(c, hsc_pkg::CLASS_PLAIN);
               end
            end
            hsc_pkg::PH_OPEN: begin
               if (held_n < 4 && c == pat_byte(comment_open, held_n)) begin
                  if (held_n == 4'd3) begin
                     flush_held(hsc_pkg::CLASS_COMMENT);
                     emit(c, hsc_pkg::CLASS_COMMENT);
                     dash_cnt = 2'd2;
                     phase = hsc_pkg::PH_COMMENT;
                  end else begin
                     held[held_n[2:0]] = c;
                     held_n++;
                  end
               end else begin
                  opener_failed(c);
               end
            end
            hsc_pkg::PH_TAG, hsc_pkg::PH_TAG_EQ: tag_byte(c);
            hsc_pkg::PH_QUOTE: begin
               emit(c, hsc_pkg::CLASS_QUOTED);
               if (c == (quote_single ? ASCII_SQUOTE : ASCII_DQUOTE)) phase = hsc_pkg::PH_TAG;
            end
            hsc_pkg::PH_COMMENT: begin
               emit(c, hsc_pkg::CLASS_COMMENT);
               if (c == ASCII_DASH) begin
                  if (dash_cnt < 2'd2) dash_cnt++;
               end else if (c == ASCII_GT && dash_cnt == 2'd2) begin
                  dash_cnt = '0;
                  phase = hsc_pkg::PH_PLAIN;
               end else begin
                  dash_cnt = '0;
               end
            end
            hsc_pkg::PH_NEST_START: nested_byte(c);
            default: emit(c, (nest_kind != KIND_NONE) ? nested_class() : hsc_pkg::CLASS_PLAIN);
         endcase
      endfunction

      function void line_done();
         case (phase)
            hsc_pkg::PH_OPEN: begin
               flush_held(hsc_pkg::CLASS_TAG);
               close_tag();
            end
            hsc_pkg::PH_TAG, hsc_pkg::PH_TAG_EQ, hsc_pkg::PH_QUOTE: close_tag();
            hsc_pkg::PH_NEST_START: flush_held(nested_class());
            default: ;
         endcase
         held_n     = '0;
         dash_cnt   = '0;
         in_attr    = 1'b0;
         match_kind = KIND_NONE;
         match_pos  = '0;
         phase = (nest_kind != KIND_NONE) ? hsc_pkg::PH_NEST_START : hsc_pkg::PH_PLAIN;
      endfunction

      // Called for every input transaction the block accepts.
      function void accept_item(logic mode, logic [7:0] c);
         step_q.delete();
         items_seen++;
         if (mode) line_done();
         else text_byte(c);
         if (step_q.size() > 0) step_q[step_q.size() - 1].is_last = 1'b1;
         foreach (step_q[i]) pending_classified.push_back(step_q[i]);
      endfunction

      // Called for every result transaction the block hands out.
      function void check_result(logic [7:0] c, logic [2:0] cls, logic is_last);
         classified_char_type want;
         results_checked++;
         if (pending_classified.size() == 0) begin
            $display("%0t: unexpected result: character %02h class %0d last %0b",
                     $time, c, cls, is_last);
            errors++;
            return;
         end
         want = pending_classified.pop_front();
         if (c !== want.ch) begin
            $display("%0t: character mismatch: expected %02h, actual %02h",
                     $time, want.ch, c);
            errors++;
         end
         if (cls !== want.cls) begin
            $display("%0t: class mismatch on %02h: expected %0d, actual %0d",
                     $time, want.ch, want.cls, cls);
            errors++;
         end
         if (is_last !== want.is_last) begin
            $display("%0t: last mismatch on %02h: expected %0b, actual %0b",
                     $time, want.ch, want.is_last, is_last);
            errors++;
         end
      endfunction
   endclass

endpackage

[dv/html_syntax_classifier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTML syntax classifier testbench
// Feeds lines of HTML-like text and end-of-line markers through the
// classifier, predicts every classified character and checks the results in
// order, under several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module html_syntax_classifier_tb;

   // The long result hold-off is the longest quiet span a correct run has, so
   // WATCHDOG_LIMIT quiet cycles can only mean the block has hung.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int NUM_PHASES = 5;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic       req_mode = 1'b0;
   logic [7:0] req_character = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_character_out;
   logic [2:0] rsp_text_class;
   logic       rsp_last;

   hsc_tb_pkg::char_class_tracker_type tracker;

   // Idle and stall odds, in percent per cycle, set by the phase sequencer.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;

   // The line being built before it is sent, one byte per entry.
   logic [7:0] line_q[$];

   string blanks      = "\011\012\013\014\015 ";
   string plain_chars = "ab <>=\"'-!/";
   string cmt_chars   = "a->! <";
   string quote_chars = "a >=\"'";
   string attr_chars  = "abcx-";
   string tag_names [9] = '{"script", "style", "scripts", "styl", "scr", "a", "div", "s", ""};
   string closers [6] = '{"</script>", "</style>", "</a>", "</scr", "</stylx>", "</"};
   string quirks [8] = '{"-->", "->", "<!-", "<!x", "<<", "<>", "<!-->", "--->"};

   int idle_by_phase [NUM_PHASES]  = '{0, 52, 0, 14, 0};
   int stall_by_phase [NUM_PHASES] = '{0, 0, 52, 14, 0};

   html_syntax_classifier dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_mode          (req_mode),
      .req_character     (req_character),
      .empty             (empty),
      .pop               (pop),
      .rsp_character_out (rsp_character_out),
      .rsp_text_class    (rsp_text_class),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one transaction, with random idle cycles in front of it, and
   // returns at the edge where the block takes it. Push stays high into the
   // next call so back-to-back transactions need no gap.
   task automatic send_item(input logic mode, input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_mode <= mode;
      req_character <= c;
      do @(posedge clock); while (full);
      tracker.accept_item(mode, c);
      items_sent++;
   endtask

   // The character is meaningless with an end-of-line marker, so it is random.
   task automatic send_eol();
      send_item(1'b1, 8'($urandom_range(255)));
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(1'b0, s[i]);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_item(1'b0, line_q[i]);
      send_eol();
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) line_q.push_back(s[i]);
   endtask

   task automatic add_pick(input string alphabet, input int n);
      repeat (n) line_q.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) line_q.push_back(8'($urandom_range(255)));
   endtask

   // Zero to two attributes: bare names, quoted values of either kind (some
   // left open so end of line has to close them) and unquoted values.
   task automatic add_attrs();
      string q;
      repeat ($urandom_range(0, 2)) begin
         add_text(" ");
         add_pick(attr_chars, $urandom_range(1, 3));
         case ($urandom_range(3))
            0: ;
            1, 2: begin
               q = $urandom_range(1) ? "\"" : "'";
               add_text("=");
               add_text(q);
               add_pick(quote_chars, $urandom_range(0, 3));
               if ($urandom_range(3) != 0) add_text(q);
            end
            default: begin
               add_text("=");
               add_pick(attr_chars, $urandom_range(1, 2));
            end
         endcase
      end
   endtask

   // One piece of an ordinary HTML line. Most pieces are well formed; the
   // rest are cut short or are raw bytes to hit the odd corners.
   task automatic add_fragment();
      case ($urandom_range(7))
         0: add_random_bytes($urandom_range(1, 4));
         1: begin
            add_text("<!--");
            add_pick(cmt_chars, $urandom_range(0, 5));
            if ($urandom_range(3) != 0) add_text("-->");
         end
         2, 3: begin
            add_text("<");
            add_text(tag_names[$urandom_range($size(tag_names) - 1)]);
            add_attrs();
            if ($urandom_range(3) != 0) add_text(">");
         end
         4: add_text(closers[$urandom_range($size(closers) - 1)]);
         5: add_pick(blanks, $urandom_range(1, 3));
         6: add_text(quirks[$urandom_range($size(quirks) - 1)]);
         default: add_pick(plain_chars, $urandom_range(1, 5));
      endcase
   endtask

   // Builds the next line from what the model says about the current mode.
   // Inside a script or style block the line often opens with blanks and a
   // full or partial closing tag, since only that decides the lookahead.
   task automatic build_line();
      string closer;
      line_q.delete();
      if (tracker.is_nested()) begin
         if ($urandom_range(1)) add_pick(blanks, $urandom_range(1, 3));
         closer = $urandom_range(1) ? "</script>" : "</style>";
         case ($urandom_range(5))
            0, 1: add_text(closer);
            2: begin
               add_text(closer.substr(0, $urandom_range(0, closer.len() - 2)));
               add_random_bytes(1);
            end
            3: add_random_bytes($urandom_range(1, 4));
            default: add_fragment();
         endcase
         repeat ($urandom_range(0, 2)) add_fragment();
      end else begin
         if ($urandom_range(4) == 0) begin
            add_text($urandom_range(1) ? "<script" : "<style");
            if ($urandom_range(1)) add_attrs();
            add_text(">");
         end
         repeat ($urandom_range(1, 3)) add_fragment();
      end
   endtask

   // Result side. The rsp ports and empty are sampled at the edge, before the
   // block updates them, and pop is redrawn for the next cycle. A hold-off
   // request from the sequencer keeps pop low for a long stretch.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty)
            tracker.check_result(rsp_character_out, rsp_text_class, rsp_last);
         if (hold_off_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: any cycle without a transaction on either side counts.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results still owed",
                  $time, WATCHDOG_LIMIT, tracker.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: the byte extremes, a comment that closes right on
      // its opener, an end of line with nothing held, a style block that is
      // opened and then closed on the next line, and a lookahead that end of
      // line cuts short.
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_text("<!-->");
      send_eol();
      send_text("<style>");
      send_eol();
      send_text("</style>");
      send_eol();
      send_text("<!");
      send_eol();

      // Random lines in phases of different idle and stall odds. The last
      // phase sends flat out while the result side is held off, so the
      // block has to fill up and raise full.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         int start_count;
         start_count = items_sent;
         send_idle_pct = idle_by_phase[ph];
         recv_stall_pct = stall_by_phase[ph];
         if (ph == NUM_PHASES - 1) hold_off_request = 1'b1;
         while (items_sent - start_count < ITEMS_PER_PHASE) begin
            build_line();
            send_line();
         end
      end
      push <= 1'b0;

      // Drain, then give the block a few more cycles to show any stray result.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d input transactions and checked %0d results over %0d phases.",
               tracker.items_seen, tracker.results_checked, NUM_PHASES);
      $display("Script or style blocks entered %0d times; one long result hold-off.",
               tracker.nest_entries);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
